FILE: hdl/ktts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ktts_pkg;

   localparam int ENTRIES_DEF = 32;
   localparam int KEY_W       = 32;
   localparam int ENTRY_W     = KEY_W + 1;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STS_EXISTS    = 2'd2;
   localparam logic [1:0] STS_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       prior_state;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } res_type;

endpackage
`default_nettype wire

FILE: hdl/ktts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ktts_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: hdl/ktts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ktts_ctrl #(
   parameter int ENTRIES = ktts_pkg::ENTRIES_DEF,
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int CNT_W = $clog2(ENTRIES + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire ktts_pkg::req_type              req_data,
   output ktts_pkg::res_type                   res,
   input  wire logic                           res_ready,
   output logic                                wr_en,
   output logic [IDX_W-1:0]                    wr_addr,
   output logic [ktts_pkg::ENTRY_W-1:0]        wr_data,
   output logic                                rd_en,
   output logic [IDX_W-1:0]                    rd_addr,
   input  wire logic [ktts_pkg::ENTRY_W-1:0]   rd_data
);
   import ktts_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_RES  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] pend_addr_ff, pend_addr_in;
   logic [1:0]       status_ff, status_in;
   logic             prior_ff, prior_in;

   logic             accept;
   logic [1:0]       op_sel;
   logic [KEY_W-1:0] key_sel;
   logic             hit;
   logic             last;
   logic             miss;
   logic             full;
   logic             issue;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign op_sel    = (state_ff == S_IDLE) ? req_data.opcode : op_ff;
   assign key_sel   = (state_ff == S_IDLE) ? req_data.key : key_ff;
   assign full      = (count_ff == CNT_W'(ENTRIES));
   assign hit       = (state_ff == S_SCAN) && pend_ff && (rd_data[ENTRY_W-1:1] == key_ff);
   assign last      = (pend_addr_ff == CNT_W'(count_ff - CNT_W'(1)));
   assign miss      = (accept && (count_ff == '0)
                       && (req_data.opcode == OP_LOOKUP || req_data.opcode == OP_INSERT))
                    || ((state_ff == S_SCAN) && pend_ff && !hit && last);
   assign issue     = (state_ff == S_SCAN) && !hit && !miss && (idx_ff < count_ff);

   assign rd_en      = issue;
   assign rd_addr    = idx_ff[IDX_W-1:0];
   assign res.valid  = (state_ff == S_RES);
   assign res.data.status      = status_ff;
   assign res.data.prior_state = prior_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      status_in    = status_ff;
      prior_in     = prior_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff[IDX_W-1:0];
      wr_data      = {key_ff, ~rd_data[0]};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_data.opcode;
               key_in    = req_data.key;
               idx_in    = '0;
               status_in = STS_OK;
               prior_in  = 1'b0;
               if (req_data.opcode == OP_CLEAR) begin
                  count_in = '0;
                  state_in = S_RES;
               end else if (miss || req_data.opcode == OP_UNUSED) begin
                  state_in = S_RES;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               idx_in       = CNT_W'(idx_ff + CNT_W'(1));
               pend_in      = 1'b1;
               pend_addr_in = idx_ff;
            end
            if (hit) begin
               wr_en     = 1'b1;
               prior_in  = rd_data[0];
               status_in = (op_ff == OP_INSERT) ? STS_EXISTS : STS_OK;
               state_in  = S_RES;
            end else if (miss) begin
               state_in = S_RES;
            end
         end
         S_RES: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // miss: lookup reports not found, insert appends or is refused
      if (miss) begin
         prior_in = 1'b0;
         if (op_sel == OP_LOOKUP) begin
            status_in = STS_NOT_FOUND;
         end else if (full) begin
            status_in = STS_FULL;
         end else begin
            status_in = STS_OK;
            wr_en     = 1'b1;
            wr_addr   = count_ff[IDX_W-1:0];
            wr_data   = {key_sel, 1'b0};
            count_in  = CNT_W'(count_ff + CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      status_ff    <= status_in;
      prior_ff     <= prior_in;
   end

endmodule
`default_nettype wire

FILE: hdl/key_table_toggle_store_unit.sv
// A request is registered, then the S_SCAN state reads entries up to the match (all in
// use on a miss); an empty table, a clear or an unused opcode go straight to S_RES.
// A new request is stalled until the result leaves S_RES; the scan reads one entry
// a cycle through the single read port of the table memory, then writes back the entry.
// A new request is taken while the previous result still waits at the output register.
// Reset empties the table (entry count to zero); memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module key_table_toggle_store_unit #(
   parameter int ENTRIES = ktts_pkg::ENTRIES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ktts_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ktts_pkg::rsp_type      rsp_data
);
   import ktts_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   res_type            res;
   logic               res_ready;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   ktts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ktts_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .res       (res),
      .res_ready (res_ready),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res.valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
